### hdl/wrrtq_pkg.sv
// Package for the weighted round-robin task queue.
// Holds the sizes, codes and transaction types shared by all hdl files.
// No dependencies.
package wrrtq_pkg;

  // Sizes
  localparam int MaxTasks = 16;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CountW   = $clog2(MaxTasks + 1);
  localparam int TaskW    = 4;
  localparam int WeightW  = 8;
  localparam int BaseW    = 10;
  localparam int SliceW   = 18;

  // Reset values
  localparam int Hz = 100;
  localparam logic [SliceW-1:0] SliceReset     = SliceW'(100 * Hz / 1000);
  localparam logic [BaseW-1:0]  BaseSliceReset = BaseW'(10);
  localparam logic [WeightW-1:0] WeightReset   = WeightW'(1);

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  typedef enum logic [0:0] {
    CfgBaseSlice = 1'b0
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ActEnqueue   = 3'd0,
    ActDequeue   = 3'd1,
    ActYield     = 3'd2,
    ActTick      = 3'd3,
    ActSetWeight = 3'd4,
    ActQuery     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StDone       = 2'd0,
    StMembership = 2'd1,
    StWeightZero = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [TaskW-1:0]   task_id;
    logic [WeightW-1:0] new_weight;
  } in_item_t;

  typedef struct packed {
    logic [TaskW-1:0]  head_task;
    logic [CountW-1:0] queue_length;
    logic              need_resched;
    logic [SliceW-1:0] slice_left;
    logic [1:0]        status;
  } out_item_t;

  // Command from the control logic to the run queue
  typedef struct packed {
    logic             remove;
    logic             append;
    logic [TaskW-1:0] task_id;
  } queue_cmd_t;

  // Run queue view after the pending command is applied
  typedef struct packed {
    logic [TaskW-1:0]  head_task;
    logic [CountW-1:0] queue_length;
  } queue_view_t;

endpackage

### hdl/wrrtq_queue.sv
// FIFO run queue with remove-from-anywhere and append, compare-and-shift form.
// Keeps order, count and per-task membership bits.
// Depends on wrrtq_pkg.
module wrrtq_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrrtq_pkg::queue_cmd_t               cmd_i,
  output logic [wrrtq_pkg::MaxTasks-1:0]      in_queue_o,
  output wrrtq_pkg::queue_view_t              view_o
);

  logic [wrrtq_pkg::TaskW-1:0]  order_q [wrrtq_pkg::MaxTasks];
  logic [wrrtq_pkg::TaskW-1:0]  order_d [wrrtq_pkg::MaxTasks];
  logic [wrrtq_pkg::CountW-1:0] count_q, count_d, count_rm;
  logic [wrrtq_pkg::MaxTasks-1:0] member_q, member_d;
  logic [wrrtq_pkg::MaxTasks-1:0] match;
  logic [wrrtq_pkg::MaxTasks-1:0] passed;

  // Locate the task and mark every slot at or after it
  always_comb begin
    for (int i = 0; i < wrrtq_pkg::MaxTasks; i++) begin
      match[i] = (order_q[i] == cmd_i.task_id) &&
                 (wrrtq_pkg::CountW'(i) < count_q);
    end
    passed[0] = match[0];
    for (int i = 1; i < wrrtq_pkg::MaxTasks; i++) begin
      passed[i] = passed[i-1] | match[i];
    end
  end

  always_comb begin
    count_rm = cmd_i.remove ? count_q - wrrtq_pkg::CountW'(1) : count_q;
    count_d  = count_rm;
    member_d = member_q;
    for (int i = 0; i < wrrtq_pkg::MaxTasks; i++) begin
      if (cmd_i.remove && passed[i] && (i < wrrtq_pkg::MaxTasks - 1)) begin
        order_d[i] = order_q[i+1];
      end else begin
        order_d[i] = order_q[i];
      end
    end
    if (cmd_i.remove) begin
      member_d[cmd_i.task_id[wrrtq_pkg::IdxW-1:0]] = 1'b0;
    end
    if (cmd_i.append && (count_rm < wrrtq_pkg::CountW'(wrrtq_pkg::MaxTasks))) begin
      order_d[count_rm[wrrtq_pkg::IdxW-1:0]] = cmd_i.task_id;
      count_d = count_rm + wrrtq_pkg::CountW'(1);
      member_d[cmd_i.task_id[wrrtq_pkg::IdxW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      member_q <= '0;
    end else begin
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  // Order entries are only read below count, so they carry no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < wrrtq_pkg::MaxTasks; i++) begin
      order_q[i] <= order_d[i];
    end
  end

  assign in_queue_o          = member_q;
  assign view_o.queue_length = count_d;
  assign view_o.head_task    = (count_d != '0) ? order_d[0] : '0;

endmodule

### hdl/weighted_round_robin_task_queue.sv
// Weighted round-robin task queue: top level.
// Holds per-task weight and slice, the configuration register and the result register.
// Depends on wrrtq_pkg and wrrtq_queue.

// One input transaction is accepted per clock and its result transaction appears in
// the output register on the next cycle, so the sustained rate is one item per cycle.
// The whole step (membership check, slice update with one 10x8 multiply for the
// reload value, compare-and-shift removal and tail append in the run queue) is done
// in a single combinational pass between the input handshake and the result register.
// The input is stalled only while a result sits in the output register and the
// consumer is stalling it. base_slice_ticks (APB, byte address 0) resets to 10 and
// should only be written while no transaction is in flight. After reset every task
// has weight 1 and slice 10 and the run queue is empty; no clearing pass is needed.

module weighted_round_robin_task_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  wrrtq_pkg::in_item_t                in_data_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output wrrtq_pkg::out_item_t               out_data_o,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wrrtq_pkg::PaddrW-1:0]       paddr,
  input  logic [wrrtq_pkg::PdataW-1:0]       pwdata,
  output logic [wrrtq_pkg::PdataW-1:0]       prdata,
  output logic                               pready
);

  // Configuration
  logic [wrrtq_pkg::BaseW-1:0] base_q;
  logic                        cfg_wr;

  // Per-task state
  logic [wrrtq_pkg::WeightW-1:0] weight_q [wrrtq_pkg::MaxTasks];
  logic [wrrtq_pkg::SliceW-1:0]  slice_q  [wrrtq_pkg::MaxTasks];

  // Step logic
  logic                           in_accept;
  logic [wrrtq_pkg::IdxW-1:0]     tidx;
  logic [wrrtq_pkg::MaxTasks-1:0] in_queue;
  logic                           member;
  logic [wrrtq_pkg::WeightW-1:0]  mul_weight;
  logic [wrrtq_pkg::SliceW-1:0]   reload;
  logic [wrrtq_pkg::SliceW-1:0]   slice_cur;
  logic [wrrtq_pkg::SliceW-1:0]   slice_new;
  logic                           slice_wr;
  logic                           weight_wr;
  logic                           resched;
  wrrtq_pkg::status_e             status;
  wrrtq_pkg::queue_cmd_t          qcmd;
  wrrtq_pkg::queue_view_t         qview;

  // Result register
  logic                  out_valid_q;
  wrrtq_pkg::out_item_t  out_data_q;
  wrrtq_pkg::out_item_t  out_data_d;

  // ---------------------------------------------------------------------------
  // APB register: index is paddr[2], low bits ignored
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == wrrtq_pkg::CfgBaseSlice);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= wrrtq_pkg::BaseSliceReset;
    end else if (cfg_wr) begin
      base_q <= pwdata[wrrtq_pkg::BaseW-1:0];
    end
  end

  assign prdata = (paddr[2] == wrrtq_pkg::CfgBaseSlice) ?
                  wrrtq_pkg::PdataW'(base_q) : '0;

  // ---------------------------------------------------------------------------
  // Handshake: take a transaction unless a stalled result blocks the register
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign tidx      = in_data_i.task_id[wrrtq_pkg::IdxW-1:0];
  assign member    = in_queue[tidx];
  assign slice_cur = slice_q[tidx];

  // Reload value: base times the new weight on set weight, the stored weight on tick.
  // 1023 * 255 fits in 18 bits, so the product is exact.
  assign mul_weight = (in_data_i.action == wrrtq_pkg::ActSetWeight) ?
                      in_data_i.new_weight : weight_q[tidx];
  assign reload     = wrrtq_pkg::SliceW'(base_q) * wrrtq_pkg::SliceW'(mul_weight);

  always_comb begin
    status       = wrrtq_pkg::StDone;
    resched      = 1'b0;
    slice_wr     = 1'b0;
    weight_wr    = 1'b0;
    slice_new    = reload;
    qcmd.remove  = 1'b0;
    qcmd.append  = 1'b0;
    qcmd.task_id = in_data_i.task_id;
    case (in_data_i.action)
      wrrtq_pkg::ActEnqueue: begin
        if (member) status = wrrtq_pkg::StMembership;
        else        qcmd.append = 1'b1;
      end
      wrrtq_pkg::ActDequeue: begin
        if (!member) status = wrrtq_pkg::StMembership;
        else         qcmd.remove = 1'b1;
      end
      wrrtq_pkg::ActYield: begin
        if (!member) begin
          status = wrrtq_pkg::StMembership;
        end else begin
          qcmd.remove = 1'b1;
          qcmd.append = 1'b1;
        end
      end
      wrrtq_pkg::ActTick: begin
        if (!member) begin
          status = wrrtq_pkg::StMembership;
        end else if (slice_cur > wrrtq_pkg::SliceW'(1)) begin
          slice_wr  = 1'b1;
          slice_new = slice_cur - wrrtq_pkg::SliceW'(1);
        end else begin
          // slice used up (zero counts as used up): reload and rotate
          slice_wr    = 1'b1;
          qcmd.remove = 1'b1;
          qcmd.append = 1'b1;
          resched     = 1'b1;
        end
      end
      wrrtq_pkg::ActSetWeight: begin
        if (in_data_i.new_weight == '0) begin
          status = wrrtq_pkg::StWeightZero;
        end else begin
          weight_wr = 1'b1;
          slice_wr  = 1'b1;
        end
      end
      default: begin
        // query and unused codes: report only
      end
    endcase
    // nothing touches state unless the transaction is accepted
    if (!in_accept) begin
      qcmd.remove = 1'b0;
      qcmd.append = 1'b0;
      slice_wr    = 1'b0;
      weight_wr   = 1'b0;
    end
  end

  wrrtq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (qcmd),
    .in_queue_o (in_queue),
    .view_o     (qview)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wrrtq_pkg::MaxTasks; i++) begin
        weight_q[i] <= wrrtq_pkg::WeightReset;
        slice_q[i]  <= wrrtq_pkg::SliceReset;
      end
    end else begin
      if (weight_wr) weight_q[tidx] <= in_data_i.new_weight;
      if (slice_wr)  slice_q[tidx]  <= slice_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_data_d.head_task    = qview.head_task;
    out_data_d.queue_length = qview.queue_length;
    out_data_d.need_resched = resched;
    out_data_d.slice_left   = slice_wr ? slice_new : slice_cur;
    out_data_d.status       = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/wrrtq_checker.sv
// Port-level checker for the weighted round-robin task queue, with its bind.
// Depends on wrrtq_pkg and weighted_round_robin_task_queue.
module wrrtq_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input wrrtq_pkg::out_item_t  out_data_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every accepted transaction yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // a reschedule only comes from a completed tick, which leaves the task queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.need_resched |->
      (out_data_o.status == wrrtq_pkg::StDone) && (out_data_o.queue_length != '0))
    else $error("reschedule with bad status or empty queue");

  // empty queue reports head task zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.queue_length == '0) |-> (out_data_o.head_task == '0))
    else $error("empty queue with nonzero head");

endmodule

bind weighted_round_robin_task_queue wrrtq_checker u_wrrtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### dv/tb_weighted_round_robin_task_queue.sv
// Self-checking testbench for the weighted round-robin task queue.
// Runs directed and random scheduler actions and checks each result against a predictor.
// Depends on wrrtq_pkg and the weighted_round_robin_task_queue RTL.
`timescale 1ns / 1ps

module tb_weighted_round_robin_task_queue;
  import wrrtq_pkg::*;

  // Action codes the block treats as a query
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;

  // APB byte addresses: base slice register, and an address with no register behind it
  localparam logic [PaddrW-1:0] BaseSliceAddr = {CfgBaseSlice, 2'b00};
  localparam logic [PaddrW-1:0] UnusedAddr    = PaddrW'(4);

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // DUT ports; the inputs are driven to known values from time zero
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PaddrW-1:0]   paddr       = '0;
  logic [PdataW-1:0]   pwdata      = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  weighted_round_robin_task_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Action transactions waiting to be offered, and results predicted but not yet seen
  in_item_t  action_q[$];
  out_item_t sched_results_q[$];

  // Scheduler shadow state used for prediction
  logic [BaseW-1:0]   pred_base;
  logic [TaskW-1:0]   pred_order[$];       // run queue, head first
  logic               pred_queued[MaxTasks];
  logic [WeightW-1:0] pred_weight[MaxTasks];
  logic [SliceW-1:0]  pred_slice[MaxTasks];

  // Membership as seen by the stimulus generator; only enqueue/dequeue change it
  logic gen_member[MaxTasks];

  // Idle control: percent chance per cycle to start an idle burst (0 = none)
  int   idle_pct  = 0;
  logic hold_go   = 1'b0;   // kicks off the long receiver hold-off
  logic hold_long = 1'b0;

  // Bookkeeping
  int n_fail    = 0;
  int n_results = 0;
  int n_resched = 0;
  int n_refused = 0;
  int n_cfg     = 0;
  int peak_len  = 0;

  // Reload value: base ticks times weight, kept to the slice width
  function automatic logic [SliceW-1:0] reload_slice(input logic [BaseW-1:0] b,
                                                     input logic [WeightW-1:0] w);
    logic [BaseW+WeightW-1:0] prod;
    prod = b * w;
    return prod[SliceW-1:0];
  endfunction

  task automatic drop_task(input logic [TaskW-1:0] t);
    for (int i = pred_order.size() - 1; i >= 0; i--) begin
      if (pred_order[i] == t) pred_order.delete(i);
    end
    pred_queued[t] = 1'b0;
  endtask

  task automatic move_to_tail(input logic [TaskW-1:0] t);
    drop_task(t);
    pred_order.push_back(t);
    pred_queued[t] = 1'b1;
  endtask

  // Apply one action to the shadow scheduler and form the result it should produce
  task automatic schedule_step(input in_item_t it, output out_item_t res);
    logic [TaskW-1:0] t;
    status_e          st;
    logic             resched;
    t       = it.task_id;
    st      = StDone;
    resched = 1'b0;
    case (it.action)
      ActEnqueue: begin
        if (pred_queued[t]) begin
          st = StMembership;
        end else if (pred_order.size() < MaxTasks) begin
          pred_order.push_back(t);
          pred_queued[t] = 1'b1;
        end
      end
      ActDequeue: begin
        if (!pred_queued[t]) st = StMembership;
        else drop_task(t);
      end
      ActYield: begin
        if (!pred_queued[t]) st = StMembership;
        else move_to_tail(t);
      end
      ActTick: begin
        if (!pred_queued[t]) begin
          st = StMembership;
        end else if (pred_slice[t] > 1) begin
          pred_slice[t] = pred_slice[t] - 1'b1;
        end else begin
          // slice used up (or already empty): reload and rotate
          pred_slice[t] = reload_slice(pred_base, pred_weight[t]);
          move_to_tail(t);
          resched = 1'b1;
        end
      end
      ActSetWeight: begin
        if (it.new_weight == '0) begin
          st = StWeightZero;
        end else begin
          pred_weight[t] = it.new_weight;
          pred_slice[t]  = reload_slice(pred_base, it.new_weight);
        end
      end
      default: ;  // query and the spare codes change nothing
    endcase
    res.head_task    = (pred_order.size() > 0) ? pred_order[0] : '0;
    res.queue_length = CountW'(pred_order.size());
    res.need_resched = resched;
    res.slice_left   = pred_slice[t];
    res.status       = st;
  endtask

  // Compare one result transaction with the oldest prediction, field by field
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (sched_results_q.size() == 0) begin
      $error("result transaction with no prediction pending: %p", got);
      n_fail++;
      return;
    end
    want = sched_results_q.pop_front();
    if (got.head_task !== want.head_task) begin
      $error("head_task: expected %0d, got %0d", want.head_task, got.head_task);
      n_fail++;
    end
    if (got.queue_length !== want.queue_length) begin
      $error("queue_length: expected %0d, got %0d", want.queue_length, got.queue_length);
      n_fail++;
    end
    if (got.need_resched !== want.need_resched) begin
      $error("need_resched: expected %0d, got %0d", want.need_resched, got.need_resched);
      n_fail++;
    end
    if (got.slice_left !== want.slice_left) begin
      $error("slice_left: expected %0d, got %0d", want.slice_left, got.slice_left);
      n_fail++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      n_fail++;
    end
    n_results++;
    if (want.need_resched) n_resched++;
    if (want.status != StDone) n_refused++;
    if (int'(want.queue_length) > peak_len) peak_len = int'(want.queue_length);
  endtask

  // Driver: predicts on acceptance, then offers the next transaction. The payload only
  // moves when the current one was taken or nothing is offered.
  int drv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      drv_gap    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        schedule_step(in_data_i, res);
        sched_results_q.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          drv_gap = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (action_q.size() > 0) begin
          in_data_i  <= action_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result, then picks the stall for the next cycle
  int mon_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_gap     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (hold_long) begin
        out_stall_i <= 1'b1;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        mon_gap = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the result register fills
  // and the block has to stall its input.
  initial begin
    while (!hold_go) @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (250) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  task automatic push_item(input logic [2:0] act, input int t, input int w);
    in_item_t it;
    it.action     = act;
    it.task_id    = TaskW'(t);
    it.new_weight = WeightW'(w);
    if (act == ActEnqueue) gen_member[it.task_id] = 1'b1;
    if (act == ActDequeue) gen_member[it.task_id] = 1'b0;
    action_q.push_back(it);
  endtask

  // Random actions, mostly aimed at queued tasks so ticks actually run slices down.
  // wmax bounds the ordinary weights; zero and 255 are mixed in as well.
  task automatic queue_random_items(input int n, input int wmax);
    logic [2:0] act;
    int         t;
    int         w;
    int         r;
    int         members[$];
    int         idle_tasks[$];
    for (int k = 0; k < n; k++) begin
      members.delete();
      idle_tasks.delete();
      for (int i = 0; i < MaxTasks; i++) begin
        if (gen_member[i]) members.push_back(i);
        else idle_tasks.push_back(i);
      end
      r = $urandom_range(0, 99);
      if (r < 20)      act = ActEnqueue;
      else if (r < 30) act = ActDequeue;
      else if (r < 40) act = ActYield;
      else if (r < 72) act = ActTick;
      else if (r < 84) act = ActSetWeight;
      else if (r < 94) act = ActQuery;
      else             act = $urandom_range(0, 1) ? ActSpare6 : ActSpare7;
      if ((act == ActDequeue || act == ActYield || act == ActTick) &&
          members.size() > 0 && $urandom_range(0, 99) < 85)
        t = members[$urandom_range(0, members.size() - 1)];
      else if (act == ActEnqueue && idle_tasks.size() > 0 && $urandom_range(0, 99) < 80)
        t = idle_tasks[$urandom_range(0, idle_tasks.size() - 1)];
      else
        t = $urandom_range(0, MaxTasks - 1);
      if (act == ActSetWeight) begin
        r = $urandom_range(0, 99);
        w = (r < 8) ? 0 : (r < 16) ? 255 : $urandom_range(1, wmax);
      end else begin
        w = $urandom_range(0, 255);   // ignored, but its bits still toggle
      end
      push_item(act, t, w);
    end
  endtask

  // Wait until every action has been taken and every result has come back
  task automatic drain();
    while (action_q.size() != 0 || in_valid_i || sched_results_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] a, input logic [PdataW-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PaddrW-1:0] a, output logic [PdataW-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read the base slice register back and compare with the shadow copy
  task automatic check_base();
    logic [PdataW-1:0] rd;
    apb_read(BaseSliceAddr, rd);
    if (rd !== PdataW'(pred_base)) begin
      $error("base_slice_ticks: expected %0d, got %0d", pred_base, rd);
      n_fail++;
    end
  endtask

  // Only called with the block drained
  task automatic set_base(input int v);
    apb_write(BaseSliceAddr, PdataW'(v));
    pred_base = BaseW'(v);
    n_cfg++;
    check_base();
  endtask

  // Main sequence
  initial begin
    pred_base = BaseSliceReset;
    for (int i = 0; i < MaxTasks; i++) begin
      pred_queued[i] = 1'b0;
      pred_weight[i] = WeightReset;
      pred_slice[i]  = SliceReset;
      gen_member[i]  = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    check_base();   // reset value

    // Directed, reset base: empty queue, absent tasks, duplicate, weight zero,
    // weight on an unqueued task, the spare codes
    push_item(ActQuery,     0,  255);
    push_item(ActDequeue,   3,  0);
    push_item(ActYield,     3,  0);
    push_item(ActTick,      3,  0);
    push_item(ActEnqueue,   0,  0);
    push_item(ActEnqueue,   15, 0);
    push_item(ActEnqueue,   0,  0);
    push_item(ActSetWeight, 15, 0);
    push_item(ActSetWeight, 15, 255);
    push_item(ActSetWeight, 7,  1);
    push_item(ActTick,      15, 0);
    push_item(ActYield,     0,  0);
    push_item(ActSpare6,    15, 0);
    push_item(ActSpare7,    0,  255);
    push_item(ActDequeue,   15, 0);
    drain();

    // Base 1: tick with one tick left rotates and reloads
    set_base(1);
    push_item(ActSetWeight, 0, 1);
    push_item(ActTick,      0, 0);
    drain();

    // Base 0: reload gives an empty slice, and ticking an empty slice still rotates
    set_base(0);
    push_item(ActSetWeight, 0, 5);
    push_item(ActTick,      0, 0);
    push_item(ActDequeue,   0, 0);
    drain();

    // A write to an address with no register must leave the base alone
    apb_write(UnusedAddr, PdataW'(5));
    check_base();

    // Random phases over several base settings, extremes included
    set_base(1000);
    idle_pct = 20;
    queue_random_items(200, 255);
    drain();

    set_base($urandom_range(1, 4));
    idle_pct = 30;
    hold_go  = 1'b1;
    queue_random_items(400, 4);
    drain();

    set_base(1);
    idle_pct = 15;
    queue_random_items(200, 3);
    drain();

    set_base($urandom_range(1, 1000));
    idle_pct = 25;
    queue_random_items(200, 255);
    drain();

    // Final stretch runs back to back on both sides
    set_base(3);
    idle_pct = 0;
    queue_random_items(300, 4);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d result transactions across %0d base slice settings.",
             n_results, n_cfg);
    $display("Saw %0d reschedules, %0d refused actions, peak queue depth %0d.",
             n_resched, n_refused, peak_len);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### weighted_round_robin_task_queue.f
hdl/wrrtq_pkg.sv
hdl/wrrtq_queue.sv
hdl/weighted_round_robin_task_queue.sv
hdl/wrrtq_checker.sv
dv/tb_weighted_round_robin_task_queue.sv
